[rtl/core/sliding_window_average_unit_assert.svh]
// Assertion macros for the sliding window average unit.
// Each macro expects clk and rst_n in the scope of its use.
`ifndef SLIDING_WINDOW_AVERAGE_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_AVERAGE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/swa_pkg.sv]
// Shared types and constants for the sliding window average unit.
// No dependencies; used by swa_cfg_if, the divider and the top level.
package swa_pkg;

  localparam int WIN_W = 8;

  typedef struct packed {
    logic busy;
    logic done;
  } swa_div_status_t;

endpackage

[rtl/core/swa_sample_if.sv]
// Input channel: one sample transaction with its record end flag.
// No dependencies.
interface swa_sample_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          record_end;

  modport source (output valid, sample, record_end, input ready);
  modport sink   (input valid, sample, record_end, output ready);
endinterface

[rtl/core/swa_average_if.sv]
// Result channel: one average transaction with its record end flag.
// No dependencies.
interface swa_average_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;
  logic                          record_end_out;

  modport source (output valid, average, record_end_out, input ready);
  modport sink   (input valid, average, record_end_out, output ready);
endinterface

[rtl/core/swa_cfg_if.sv]
// Configuration write channel carrying the window length register.
// Depends on swa_pkg.
interface swa_cfg_if ();
  logic                       valid;
  logic                       ready;
  logic [swa_pkg::WIN_W-1:0]  window_length;

  modport source (output valid, window_length, input ready);
  modport sink   (input valid, window_length, output ready);
endinterface

[rtl/core/swa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/swa_divider.sv]
// Bit-serial restoring divider: signed dividend over unsigned nonzero divisor,
// quotient truncated toward zero. Depends on swa_pkg.
module swa_divider #(
  parameter int DIVIDEND_W = 24,
  parameter int DIVISOR_W  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [DIVIDEND_W-1:0]  dividend,
  input  logic [DIVISOR_W-1:0]          divisor,
  output swa_pkg::swa_div_status_t      status,
  output logic signed [DIVIDEND_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVIDEND_W-1:0] q_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  d_r;
  logic                  neg_r;

  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;
  logic [DIVIDEND_W-1:0] mag;

  assign mag     = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
  assign shifted = {rem_r, q_r[DIVIDEND_W-1]};
  assign fits    = shifted >= {1'b0, d_r};
  assign diff    = shifted - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DIVIDEND_W);
      q_r    <= mag;
      rem_r  <= '0;
      d_r    <= divisor;
      neg_r  <= dividend[DIVIDEND_W-1];
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
        q_r   <= {q_r[DIVIDEND_W-2:0], fits};
        rem_r <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      end else begin
        busy_r <= 1'b0;
      end
    end
  end

  assign status.busy = busy_r;
  assign status.done = busy_r && (cnt_r == '0);
  assign quotient    = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

[rtl/core/sliding_window_average_unit.sv]
// Boxcar moving average over signed fixed-point samples grouped into records.
// Depends on swa_pkg, the channel interfaces, swa_ram and swa_divider.
//
// One sample transaction is taken at a time. A sample that yields an average
// passes through the bit-serial divider, which retires one quotient bit per
// cycle. The running sum is kept incrementally: each sample adds itself and,
// once the window has filled, drops the sample one window back, read from
// the history RAM. After a write of window_length, the next sample rebuilds
// the sum over the last min(fill, window) samples, fill counting that
// sample, from the RAM through its single read port, with one ST_RS_REQ and
// ST_RS_ACC pair per held sample. The history RAM needs no clearing after
// reset; a finished average waits in the output register while the next
// sample is taken.
module sliding_window_average_unit #(
  parameter int MAX_WINDOW  = 255,
  parameter int SAMPLE_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  swa_sample_if.sink    in_if,
  swa_average_if.source out_if,
  swa_cfg_if.sink       cfg_if
);
  `include "sliding_window_average_unit_assert.svh"

  localparam int DEPTH  = MAX_WINDOW + 1;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + FILL_W;
  localparam int WIN_W  = swa_pkg::WIN_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_UPD, ST_RS_REQ, ST_RS_ACC, ST_DECIDE, ST_DIV, ST_EMIT
  } state_t;

  function automatic logic signed [SUM_W-1:0] sext(input logic [SAMPLE_BITS-1:0] v);
    return {{(SUM_W-SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
  endfunction

  function automatic logic [PTR_W-1:0] ptr_sub(input logic [PTR_W-1:0] a,
                                               input logic [FILL_W-1:0] k);
    logic [PTR_W:0] t;
    if ((PTR_W+1)'(a) >= (PTR_W+1)'(k)) begin
      t = (PTR_W+1)'(a) - (PTR_W+1)'(k);
    end else begin
      t = (PTR_W+1)'(a) + (PTR_W+1)'(DEPTH) - (PTR_W+1)'(k);
    end
    return t[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] a);
    return (a == PTR_W'(MAX_WINDOW)) ? '0 : a + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] a);
    return (a == '0) ? PTR_W'(MAX_WINDOW) : a - PTR_W'(1);
  endfunction

  state_t                  state_r, state_nxt;
  logic [WIN_W-1:0]        cfg_win_r, cfg_win_nxt;
  logic                    resync_r, resync_nxt;
  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic [PTR_W-1:0]        wp_r, wp_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [FILL_W-1:0]       win_r, win_nxt;
  logic                    drop_r, drop_nxt;
  logic [SAMPLE_BITS-1:0]  x_r, x_nxt;
  logic                    last_r, last_nxt;
  logic [PTR_W-1:0]        ptr_r, ptr_nxt;
  logic [FILL_W-1:0]       cnt_r, cnt_nxt;
  logic [SAMPLE_BITS-1:0]  res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0]  out_avg_r, out_avg_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    in_take;
  logic [FILL_W-1:0]       win_a;
  logic [FILL_W-1:0]       fill_a;
  logic [FILL_W-1:0]       span_a;
  logic                    ram_we;
  logic [PTR_W-1:0]        ram_raddr;
  logic [SAMPLE_BITS-1:0]  ram_rdata;
  logic                    div_start;
  swa_pkg::swa_div_status_t div_stat;
  logic signed [SUM_W-1:0] div_q;

  assign in_take = (state_r == ST_IDLE) && in_if.valid;
  assign win_a   = (cfg_win_r > WIN_W'(MAX_WINDOW)) ? FILL_W'(MAX_WINDOW)
                                                    : FILL_W'(cfg_win_r);
  assign fill_a  = (fill_r == FILL_W'(MAX_WINDOW)) ? fill_r : fill_r + FILL_W'(1);
  assign span_a  = (fill_a < win_a) ? fill_a : win_a;

  swa_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_if.sample),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  swa_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (FILL_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (win_r),
    .status   (div_stat),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt     = state_r;
    cfg_win_nxt   = cfg_win_r;
    resync_nxt    = resync_r;
    fill_nxt      = fill_r;
    wp_nxt        = wp_r;
    sum_nxt       = sum_r;
    win_nxt       = win_r;
    drop_nxt      = drop_r;
    x_nxt         = x_r;
    last_nxt      = last_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_avg_nxt   = out_avg_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_raddr     = ptr_sub(wp_r, win_a);
    div_start     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          ram_we   = 1'b1;
          x_nxt    = in_if.sample;
          last_nxt = in_if.record_end;
          win_nxt  = win_a;
          drop_nxt = (win_a != '0) && (fill_r >= win_a);
          fill_nxt = fill_a;
          wp_nxt   = ptr_inc(wp_r);
          if (resync_r) begin
            resync_nxt = 1'b0;
            ptr_nxt    = ptr_dec(wp_r);
            if (win_a == '0) begin
              sum_nxt   = '0;
              state_nxt = ST_DECIDE;
            end else begin
              sum_nxt   = sext(in_if.sample);
              cnt_nxt   = span_a - FILL_W'(1);
              state_nxt = (span_a == FILL_W'(1)) ? ST_DECIDE : ST_RS_REQ;
            end
          end else begin
            state_nxt = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        if (win_r == '0) begin
          sum_nxt = '0;
        end else if (drop_r) begin
          sum_nxt = sum_r + sext(x_r) - sext(ram_rdata);
        end else begin
          sum_nxt = sum_r + sext(x_r);
        end
        state_nxt = ST_DECIDE;
      end
      ST_RS_REQ: begin
        ram_raddr = ptr_r;
        state_nxt = ST_RS_ACC;
      end
      ST_RS_ACC: begin
        sum_nxt   = sum_r + sext(ram_rdata);
        ptr_nxt   = ptr_dec(ptr_r);
        cnt_nxt   = cnt_r - FILL_W'(1);
        state_nxt = (cnt_r == FILL_W'(1)) ? ST_DECIDE : ST_RS_REQ;
      end
      ST_DECIDE: begin
        div_start = (win_r != '0) && (fill_r >= win_r);
        if (last_r) begin
          fill_nxt = '0;
          sum_nxt  = '0;
        end
        state_nxt = div_start ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          res_nxt   = div_q[SAMPLE_BITS-1:0];
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = res_r;
          out_last_nxt  = last_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cfg_if.valid) begin
      cfg_win_nxt = cfg_if.window_length;
      resync_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_win_r   <= WIN_W'(3);
      resync_r    <= 1'b0;
      fill_r      <= '0;
      wp_r        <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_win_r   <= cfg_win_nxt;
      resync_r    <= resync_nxt;
      fill_r      <= fill_nxt;
      wp_r        <= wp_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      win_r       <= win_nxt;
      drop_r      <= drop_nxt;
      x_r         <= x_nxt;
      last_r      <= last_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      res_r       <= res_nxt;
      out_avg_r   <= out_avg_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign in_if.ready           = (state_r == ST_IDLE);
  assign cfg_if.ready          = 1'b1;
  assign out_if.valid          = out_valid_r;
  assign out_if.average        = out_avg_r;
  assign out_if.record_end_out = out_last_r;

  `SWA_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= FILL_W'(MAX_WINDOW), "fill count past limit")
  `SWA_ASSERT_NOW(a_wp_bound, 1'b1, wp_r <= PTR_W'(MAX_WINDOW), "write pointer past ring end")
  `SWA_ASSERT_NOW(a_div_free, div_start, !div_stat.busy, "divider started while busy")
  `SWA_ASSERT_NEXT(a_rec_clear, (state_r == ST_DECIDE) && last_r,
                   (fill_r == '0) && (sum_r == '0), "record end did not clear state")

endmodule

[test/sliding_window_average_unit_test.sv]
// Self-checking testbench for sliding_window_average_unit: boxcar means over record streams.
// Depends on swa_pkg, swa_sample_if, swa_average_if, swa_cfg_if and the unit itself.
// A scoreboard class predicts every average; tasks drive samples and window writes.
module sliding_window_average_unit_test;

  localparam int SAMPLE_W      = 16;
  localparam int MAX_HELD      = 255;
  localparam int HISTORY_DEPTH = 256;
  localparam int TOTAL_ITEMS   = 1100;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 500000;

  typedef enum int {FULL_RANGE, RAIL, NEAR_ZERO} sample_mix_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic                record_end_out;
  } average_t;

  class window_average_scoreboard;
    logic signed [SAMPLE_W-1:0] history [HISTORY_DEPTH];
    bit [7:0]    head;
    int unsigned held;
    int unsigned window;
    average_t    pending_q[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      head       = '0;
      held       = 0;
      window     = 3;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_window(int unsigned w);
      window = w;
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] x, logic last);
      longint      total;
      int unsigned span;
      int unsigned j;
      bit [7:0]    idx;
      average_t    want;
      history[head] = x;
      head++;
      if (held < MAX_HELD) held++;
      span  = (held < window) ? held : window;
      total = 0;
      idx   = head;
      for (j = 0; j < span; j++) begin
        idx--;
        total += history[idx];
      end
      if (window != 0 && held >= window) begin
        want.average        = SAMPLE_W'(total / longint'(window));
        want.record_end_out = last;
        pending_q.push_back(want);
      end
      if (last) held = 0;
    endfunction

    function void check_average(logic [SAMPLE_W-1:0] avg, logic last);
      average_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected average %0d record_end_out %0b, none pending",
                 $time, $signed(avg), last);
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (avg !== want.average) begin
        mismatches++;
        $display("%0t: average mismatch: expected %0d, actual %0d",
                 $time, $signed(want.average), $signed(avg));
      end
      if (last !== want.record_end_out) begin
        mismatches++;
        $display("%0t: record_end_out mismatch: expected %0b, actual %0b",
                 $time, want.record_end_out, last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  swa_sample_if  #(.SAMPLE_BITS(SAMPLE_W)) sample_ch ();
  swa_average_if #(.SAMPLE_BITS(SAMPLE_W)) average_ch ();
  swa_cfg_if                               cfg_ch ();

  sliding_window_average_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (sample_ch),
    .out_if (average_ch),
    .cfg_if (cfg_ch)
  );

  window_average_scoreboard board;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned windows_used;
  bit          steady;
  bit          hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    sample_ch.valid      <= 1'b1;
    sample_ch.sample     <= x;
    sample_ch.record_end <= last;
    do @(posedge clk); while (!sample_ch.ready);
    board.note_sample(x, last);
    items_sent++;
  endtask

  task automatic send_record(input int unsigned len, input bit closed,
                             input sample_mix_t mix);
    logic signed [SAMPLE_W-1:0] pole;
    logic signed [SAMPLE_W-1:0] x;
    int unsigned k;
    pole = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    for (k = 0; k < len; k++) begin
      case (mix)
        FULL_RANGE: x = SAMPLE_W'($urandom);
        RAIL:       x = ($urandom_range(0, 7) == 0) ? ~pole : pole;
        default:    x = SAMPLE_W'($urandom_range(0, 16)) - 16'sd8;
      endcase
      send_sample(x, closed && (k == len - 1));
    end
  endtask

  task automatic settle();
    sample_ch.valid <= 1'b0;
    burst_left = 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  task automatic write_window(input logic [swa_pkg::WIN_W-1:0] w);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.window_length <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    board.set_window(w);
    windows_used++;
  endtask

  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    int unsigned stall_run;
    int unsigned hold_left;
    bit          hold_taken;
    logic        next_ready;
    mode       = 0;
    mode_left  = 0;
    stall_run  = 0;
    hold_left  = 0;
    hold_taken = 1'b0;
    average_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && average_ch.valid && average_ch.ready)
        board.check_average(average_ch.average, average_ch.record_end_out);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (mode)
        0:       next_ready = 1'b1;
        1:       next_ready = 1'($urandom_range(0, 1));
        2:       next_ready = ($urandom_range(0, 3) != 0);
        default: begin
          if (stall_run > 0) begin
            stall_run--;
            next_ready = 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            stall_run  = $urandom_range(1, 12);
            next_ready = 1'b0;
          end else begin
            next_ready = 1'b1;
          end
        end
      endcase
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end
      average_ch.ready <= next_ready;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned records;
    int unsigned r;
    int unsigned len;
    int unsigned w;
    bit          closed;
    sample_mix_t mix;
    board        = new();
    items_sent   = 0;
    burst_left   = 0;
    windows_used = 0;
    steady       = 1'b0;
    hold_req     = 1'b0;
    rst_n                <= 1'b0;
    sample_ch.valid      <= 1'b0;
    sample_ch.sample     <= '0;
    sample_ch.record_end <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.window_length <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shaaaa, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b1);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd200, 1'b0);
    settle();
    write_window(8'd1);
    send_sample(16'sd300, 1'b0);
    settle();
    write_window(8'd5);
    send_sample(16'sd400, 1'b0);
    send_sample(16'sd500, 1'b1);
    settle();
    write_window(8'd1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sd0, 1'b1);

    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      case (phase)
        0: w = 255;
        1: w = 2;
        2: w = 128;
        3: w = 1;
        default: begin
          r = $urandom_range(0, 9);
          if (r < 7)      w = $urandom_range(1, 16);
          else if (r < 9) w = $urandom_range(17, 64);
          else            w = $urandom_range(65, 255);
        end
      endcase
      settle();
      write_window(swa_pkg::WIN_W'(w));
      steady = ($urandom_range(0, 3) == 0);
      if (phase == 1) hold_req = 1'b1;
      records = (w >= 65) ? 1 : $urandom_range(2, 5);
      for (r = 0; r < records; r++) begin
        closed = !((r == records - 1) && ($urandom_range(0, 3) == 0));
        if (phase == 0)
          len = w + $urandom_range(5, 30);
        else if (w > 1 && $urandom_range(0, 4) == 0)
          len = $urandom_range(1, w - 1);
        else
          len = w + $urandom_range(0, (w >= 65) ? 25 : 12);
        mix = (phase == 0) ? RAIL : sample_mix_t'($urandom_range(0, 2));
        send_record(len, closed, mix);
      end
      phase++;
    end

    sample_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Drove %0d samples over %0d window writes; %0d averages compared, %0d mismatches.",
             items_sent, windows_used, board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
